// File: rtl/core/lpht_pkg.sv
// Shared types and constants for the linear-probe hash table.
// Used by lpht_ctrl, lpht_dp and linear_probe_hash_table; no dependencies.
package lpht_pkg;

   localparam int DEFAULT_SLOTS = 8;
   localparam int KEY_LO_W      = 64;
   localparam int KEY_HI_W      = 56;
   localparam int VALUE_W       = 31;
   localparam int SLOT_OUT_W    = 8;
   localparam int CHAR_W        = 8;
   localparam int CHAR_A        = 97;   // code of 'a', subtracted for the home slot
   localparam int REQ_DATA_W    = 152;  // key_word0, key_word1, value_in, zero pad
   localparam int RSP_DATA_W    = 40;   // slot_index, value_out, zero pad

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_STORED = 2'd0,
      ST_FULL   = 2'd1,
      ST_FOUND  = 2'd2,
      ST_MISS   = 2'd3
   } lpht_status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic            load;       // capture an accepted item
      logic            home;       // start probing at the home slot
      logic            ins_step;   // advance the insert probe
      logic            write;      // store the item at the probe slot
      logic            look;       // run a lookup probe
      logic            res_set;    // capture the result
      lpht_status_type res_status;
      logic            load_out;   // move the result to the output register
   } lpht_ctl_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_lookup;
      logic slot_free;
      logic last_probe;
      logic match;
      logic miss_done;
   } lpht_sts_type;

endpackage

// File: rtl/core/lpht_ctrl.sv
// Sequencing state machine for the linear-probe hash table.
// Depends on lpht_pkg; drives lpht_dp through lpht_ctl_type commands.
module lpht_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  lpht_pkg::lpht_sts_type sts,
   output lpht_pkg::lpht_ctl_type ctl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HOME,
      S_INS,
      S_LOOK,
      S_POST
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      ctl            = '0;
      ctl.res_status = lpht_pkg::ST_STORED;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = S_HOME;
            end
         end
         S_HOME: begin
            ctl.home = 1'b1;
            state_in = sts.is_lookup ? S_LOOK : S_INS;
         end
         S_INS: begin
            if (sts.slot_free) begin
               ctl.write      = 1'b1;
               ctl.res_set    = 1'b1;
               ctl.res_status = lpht_pkg::ST_STORED;
               state_in       = S_POST;
            end else if (sts.last_probe) begin
               ctl.res_set    = 1'b1;
               ctl.res_status = lpht_pkg::ST_FULL;
               state_in       = S_POST;
            end else begin
               ctl.ins_step = 1'b1;
            end
         end
         S_LOOK: begin
            ctl.look = 1'b1;
            if (sts.match) begin
               ctl.res_set    = 1'b1;
               ctl.res_status = lpht_pkg::ST_FOUND;
               state_in       = S_POST;
            end else if (sts.miss_done) begin
               ctl.res_set    = 1'b1;
               ctl.res_status = lpht_pkg::ST_MISS;
               state_in       = S_POST;
            end
         end
         S_POST: begin
            if (out_free) begin
               ctl.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_goes_home: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_HOME)
      else $error("accepted item did not start probing");

   a_load_out_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrote an untaken result");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      ctl.res_set |=> state_ff == S_POST)
      else $error("result captured outside completion");

endmodule

// File: rtl/core/lpht_dp.sv
// Datapath of the linear-probe hash table: key trim, home slot, probe pointer,
// slot store and result registers. Depends on lpht_pkg; steered by lpht_ctrl.
module lpht_dp #(
   parameter int TABLE_SLOTS = lpht_pkg::DEFAULT_SLOTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lpht_pkg::lpht_ctl_type               ctl,
   output lpht_pkg::lpht_sts_type               sts,
   input  logic                                 cmd,
   input  logic [lpht_pkg::KEY_LO_W-1:0]        key_word0,
   input  logic [lpht_pkg::KEY_HI_W-1:0]        key_word1,
   input  logic [lpht_pkg::VALUE_W-1:0]         value_in,
   output lpht_pkg::lpht_status_type            status,
   output logic [lpht_pkg::SLOT_OUT_W-1:0]      slot_index,
   output logic [lpht_pkg::VALUE_W-1:0]         value_out
);

   localparam int IDX_W  = $clog2(TABLE_SLOTS);
   localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
   localparam int LO_W   = lpht_pkg::KEY_LO_W;
   localparam int HI_W   = lpht_pkg::KEY_HI_W;
   localparam int VAL_W  = lpht_pkg::VALUE_W;
   localparam int SO_W   = lpht_pkg::SLOT_OUT_W;
   localparam int CH_W   = lpht_pkg::CHAR_W;
   // Offset congruent to minus 'a' modulo the slot count
   localparam int HOME_OFF = (TABLE_SLOTS - (lpht_pkg::CHAR_A % TABLE_SLOTS)) % TABLE_SLOTS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   // Item registers
   logic                  cmd_ff;
   logic [LO_W-1:0]       key_lo_ff;
   logic [HI_W-1:0]       key_hi_ff;
   logic [VAL_W-1:0]      value_ff;

   // Probe state
   logic [IDX_W-1:0]      ptr_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  rd_live_ff;
   logic                  rd_last_ff;
   logic                  rd_vld_ff;
   logic [IDX_W-1:0]      rd_ptr_ff;

   // Slot store
   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [LO_W-1:0]       mem_lo [TABLE_SLOTS];
   logic [HI_W-1:0]       mem_hi [TABLE_SLOTS];
   logic [VAL_W-1:0]      mem_val [TABLE_SLOTS];
   logic [LO_W-1:0]       rd_lo_ff;
   logic [HI_W-1:0]       rd_hi_ff;
   logic [VAL_W-1:0]      rd_val_ff;

   // Result and output registers
   lpht_pkg::lpht_status_type res_status_ff;
   logic [IDX_W-1:0]      res_slot_ff;
   logic [VAL_W-1:0]      res_value_ff;
   lpht_pkg::lpht_status_type out_status_ff;
   logic [SO_W-1:0]       out_slot_ff;
   logic [VAL_W-1:0]      out_value_ff;

   logic [LO_W-1:0]       trim_lo;
   logic [HI_W-1:0]       trim_hi;
   logic [IDX_W-1:0]      home_idx;
   logic [IDX_W-1:0]      ptr_next;
   logic                  issue;
   logic                  key_eq;

   // Zero every character after the first zero character
   always_comb begin
      logic ended;
      ended   = 1'b0;
      trim_lo = key_word0;
      trim_hi = key_word1;
      for (int i = 0; i < LO_W / CH_W; i++) begin
         if (ended) begin
            trim_lo[i*CH_W +: CH_W] = '0;
         end else if (key_word0[i*CH_W +: CH_W] == '0) begin
            ended = 1'b1;
         end
      end
      for (int i = 0; i < HI_W / CH_W; i++) begin
         if (ended) begin
            trim_hi[i*CH_W +: CH_W] = '0;
         end else if (key_word1[i*CH_W +: CH_W] == '0) begin
            ended = 1'b1;
         end
      end
   end

   // Home slot: (first char + offset) mod slot count, by restoring subtraction
   always_comb begin
      logic [15:0] rem;
      logic [15:0] sub;
      rem = 16'(key_lo_ff[CH_W-1:0]);
      for (int k = 7; k >= 0; k--) begin
         sub = 16'(TABLE_SLOTS) << k;
         if (rem >= sub) begin
            rem = rem - sub;
         end
      end
      rem = rem + 16'(HOME_OFF);
      if (rem >= 16'(TABLE_SLOTS)) begin
         rem = rem - 16'(TABLE_SLOTS);
      end
      home_idx = rem[IDX_W-1:0];
   end

   assign ptr_next = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
   assign issue    = ctl.look && (cnt_ff != CNT_W'(TABLE_SLOTS));
   assign key_eq   = (rd_lo_ff == key_lo_ff) && (rd_hi_ff == key_hi_ff);

   assign sts.is_lookup  = (cmd_ff == lpht_pkg::CMD_LOOKUP);
   assign sts.slot_free  = !valid_ff[ptr_ff];
   assign sts.last_probe = (cnt_ff == CNT_W'(TABLE_SLOTS - 1));
   assign sts.match      = rd_live_ff && rd_vld_ff && key_eq;
   assign sts.miss_done  = rd_live_ff && rd_last_ff && !(rd_vld_ff && key_eq);

   // Item capture
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff    <= cmd;
         key_lo_ff <= trim_lo;
         key_hi_ff <= trim_hi;
         value_ff  <= value_in;
      end
   end

   // Probe pointer, counter and read tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         cnt_ff     <= '0;
         rd_live_ff <= 1'b0;
         rd_last_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rd_ptr_ff  <= '0;
      end else if (ctl.home) begin
         ptr_ff     <= home_idx;
         cnt_ff     <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         if (ctl.ins_step || issue) begin
            ptr_ff <= ptr_next;
            cnt_ff <= cnt_ff + 1'b1;
         end
         rd_live_ff <= issue;
         rd_last_ff <= sts.last_probe;
         rd_vld_ff  <= valid_ff[ptr_ff];
         rd_ptr_ff  <= ptr_ff;
      end
   end

   // Valid marks
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.write) begin
         valid_ff[ptr_ff] <= 1'b1;
      end
   end

   // Slot store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.write) begin
         mem_lo[ptr_ff]  <= key_lo_ff;
         mem_hi[ptr_ff]  <= key_hi_ff;
         mem_val[ptr_ff] <= value_ff;
      end
      if (issue) begin
         rd_lo_ff  <= mem_lo[ptr_ff];
         rd_hi_ff  <= mem_hi[ptr_ff];
         rd_val_ff <= mem_val[ptr_ff];
      end
   end

   // Result capture
   always_ff @(posedge clock) begin
      if (ctl.res_set) begin
         res_status_ff <= ctl.res_status;
         case (ctl.res_status)
            lpht_pkg::ST_STORED: begin
               res_slot_ff  <= ptr_ff;
               res_value_ff <= '0;
            end
            lpht_pkg::ST_FOUND: begin
               res_slot_ff  <= rd_ptr_ff;
               res_value_ff <= rd_val_ff;
            end
            default: begin
               res_slot_ff  <= '0;
               res_value_ff <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         out_status_ff <= res_status_ff;
         out_slot_ff   <= SO_W'(res_slot_ff);
         out_value_ff  <= res_value_ff;
      end
   end

   assign status     = out_status_ff;
   assign slot_index = out_slot_ff;
   assign value_out  = out_value_ff;

   a_write_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctl.write |-> !valid_ff[ptr_ff])
      else $error("insert overwrote an occupied slot");

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.write |=> valid_ff[$past(ptr_ff)])
      else $error("written slot not marked valid");

   a_match_on_lookup: assert property (@(posedge clock) disable iff (reset)
      sts.match |-> cmd_ff == lpht_pkg::CMD_LOOKUP)
      else $error("key match outside a lookup");

endmodule

// File: rtl/core/linear_probe_hash_table.sv
// Linear-probe hash table: open-addressing key/value store, top level.
// Depends on lpht_pkg; instantiates lpht_ctrl (sequencer) and lpht_dp (datapath).
//
// Usage:
//   req channel: one item per command. tuser carries cmd (0 insert, 1 lookup);
//   tdata carries the 15-character key and, for inserts, the value.
//   rsp channel: exactly one item per command, in command order. tuser carries
//   status (stored, full/dropped, found, not found); tdata carries the slot
//   index and the matched value (zero where not applicable).
// Sequencing:
//   One command at a time. An insert probes the valid marks from the home
//   slot, one probe a cycle, up to TABLE_SLOTS probes. A lookup ends on a
//   hit or after TABLE_SLOTS probes with no match; the slot store has one
//   registered read port. The next command is accepted in the cycle after the
//   result loads into the output register.
// Reset:
//   Synchronous reset clears every valid mark, so the table comes up empty
//   and accepts an item as soon as reset is released.
// Stall:
//   A result waits in the output register while rsp_tready is low; the next
//   command still runs and holds its own result until the register frees.
module linear_probe_hash_table #(
   parameter int TABLE_SLOTS = lpht_pkg::DEFAULT_SLOTS
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [63:0] key_word0, [119:64] key_word1, [150:120] value_in, [151] zero
   input  logic [lpht_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] cmd
   input  logic                               req_tuser,
   // Response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] slot_index, [38:8] value_out, [39] zero
   output logic [lpht_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic [1:0]                         rsp_tuser
);

   localparam int LO_W  = lpht_pkg::KEY_LO_W;
   localparam int HI_W  = lpht_pkg::KEY_HI_W;
   localparam int VAL_W = lpht_pkg::VALUE_W;
   localparam int SO_W  = lpht_pkg::SLOT_OUT_W;
   localparam int RD_W  = lpht_pkg::RSP_DATA_W;

   lpht_pkg::lpht_ctl_type    ctl;
   lpht_pkg::lpht_sts_type    sts;
   lpht_pkg::lpht_status_type status;
   logic [SO_W-1:0]           slot_index;
   logic [VAL_W-1:0]          value_out;

   // Sequencer: handshakes, probe loop, result hand-off
   lpht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   // Datapath: unpack request fields straight from the bus
   lpht_dp #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .cmd        (req_tuser),
      .key_word0  (req_tdata[LO_W-1:0]),
      .key_word1  (req_tdata[LO_W+HI_W-1:LO_W]),
      .value_in   (req_tdata[LO_W+HI_W+VAL_W-1:LO_W+HI_W]),
      .status     (status),
      .slot_index (slot_index),
      .value_out  (value_out)
   );

   // Pack the response, zero-pad tdata to whole bytes
   assign rsp_tdata = {{(RD_W - SO_W - VAL_W){1'b0}}, value_out, slot_index};
   assign rsp_tuser = status;

endmodule
